FILE: rtl/mpcpw_pkg.sv
`default_nettype none
package mpcpw_pkg;

   // field widths
   localparam int RADIUS_W = 4;
   localparam int COORD_W  = 11;
   localparam int COLOR_W  = 8;
   localparam int ADDR_W   = 19;
   localparam int INDEX_W  = 10;
   localparam int STEP_W   = 4;
   localparam int DEC_W    = 8;
   localparam int OCT_W    = 3;

   // largest radius that keeps one circle within 64 writes
   localparam logic [RADIUS_W-1:0] RADIUS_LIMIT = 4'd10;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd10;

   // last octant of one recurrence step
   localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

   // register indexes
   localparam logic [0:0] REG_RADIUS = 1'b0;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic advance;
      logic gen_final;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/midpoint_circle_pixel_writer_unit.sv
// one circle: the idle state takes the circle word, then 8 * (steps of the recurrence) pixel
// words follow, at most 64, one pixel word a cycle while the output does not stall
// after the circle word is taken, the first word goes through the point and output regs
// a new circle is taken the cycle after the last pixel is generated; words in flight drain
// output stalls hold the whole pixel pipe and the generator
// synchronous active-high reset: idle, pipe empty, radius 10
`default_nettype none
module midpoint_circle_pixel_writer_unit #(
   parameter int SCREEN_COLUMNS = 240,
   parameter int SCREEN_ROWS    = 400
) (
   input  wire         clock,
   input  wire         reset,
   // circle word
   input  wire         req_tvalid,
   output logic        req_tready,
   // center_x[10:0], center_y[21:11], red[29:22], green[37:30], blue[45:38]
   input  wire [47:0]  req_tdata,
   // pixel word
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // byte_address[18:0], pixel_red[26:19], pixel_green[34:27], pixel_blue[42:35]
   output logic [47:0] rsp_tdata,
   // on_screen[0]
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast,
   // register port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire [2:0]   csr_paddr,
   input  wire [31:0]  csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   mpcpw_pkg::cmd_type    cmd;
   mpcpw_pkg::status_type status;

   logic [mpcpw_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic                           csr_write;
   logic [mpcpw_pkg::ADDR_W-1:0]   out_addr;
   logic                           out_on;
   logic [mpcpw_pkg::COLOR_W-1:0]  out_red, out_green, out_blue;

   // register write and read decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      radius_in = radius_ff;
      if (csr_write && (csr_paddr[2:2] == mpcpw_pkg::REG_RADIUS)) begin
         radius_in = csr_pwdata[mpcpw_pkg::RADIUS_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2:2])
         mpcpw_pkg::REG_RADIUS: csr_prdata = 32'(radius_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= mpcpw_pkg::RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   mpcpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mpcpw_dp #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .radius    (radius_ff),
      .center_x  (req_tdata[10:0]),
      .center_y  (req_tdata[21:11]),
      .red       (req_tdata[29:22]),
      .green     (req_tdata[37:30]),
      .blue      (req_tdata[45:38]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_addr  (out_addr),
      .out_on    (out_on),
      .out_red   (out_red),
      .out_green (out_green),
      .out_blue  (out_blue),
      .out_last  (rsp_tlast)
   );

   // pack the pixel word
   assign rsp_tdata = {5'b0, out_blue, out_green, out_red, out_addr};
   assign rsp_tuser = out_on;

endmodule
`default_nettype wire

FILE: rtl/mpcpw_ctrl.sv
`default_nettype none
module mpcpw_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire mpcpw_pkg::status_type status,
   output mpcpw_pkg::cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   // idle takes a new circle, run steps the generator whenever the pipe moves
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = status.advance;
            if (status.advance && status.gen_final) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/mpcpw_dp.sv
`default_nettype none
module mpcpw_dp #(
   parameter int SCREEN_COLUMNS = 240,
   parameter int SCREEN_ROWS    = 400
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire mpcpw_pkg::cmd_type               cmd,
   output mpcpw_pkg::status_type                 status,
   input  wire [mpcpw_pkg::RADIUS_W-1:0]         radius,
   input  wire signed [mpcpw_pkg::COORD_W-1:0]   center_x,
   input  wire signed [mpcpw_pkg::COORD_W-1:0]   center_y,
   input  wire [mpcpw_pkg::COLOR_W-1:0]          red,
   input  wire [mpcpw_pkg::COLOR_W-1:0]          green,
   input  wire [mpcpw_pkg::COLOR_W-1:0]          blue,
   output logic                                  out_valid,
   input  wire                                   out_ready,
   output logic [mpcpw_pkg::ADDR_W-1:0]          out_addr,
   output logic                                  out_on,
   output logic [mpcpw_pkg::COLOR_W-1:0]         out_red,
   output logic [mpcpw_pkg::COLOR_W-1:0]         out_green,
   output logic [mpcpw_pkg::COLOR_W-1:0]         out_blue,
   output logic                                  out_last
);

   localparam int PW = mpcpw_pkg::COORD_W + 1;
   localparam int LW = 24;
   localparam logic signed [PW-1:0] ROWS_S = PW'(SCREEN_ROWS);
   localparam logic signed [PW-1:0] COLS_S = PW'(SCREEN_COLUMNS);
   localparam logic [LW-1:0] COLS_L = LW'(SCREEN_COLUMNS);

   // recurrence and held item
   logic [mpcpw_pkg::STEP_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [mpcpw_pkg::DEC_W-1:0] d_ff, d_in;
   logic [mpcpw_pkg::OCT_W-1:0] oct_ff, oct_in;
   logic signed [mpcpw_pkg::COORD_W-1:0] cx_ff, cy_ff;
   logic [mpcpw_pkg::COLOR_W-1:0] red_ff, green_ff, blue_ff;

   // point stage
   logic pt_valid_ff, pt_valid_in;
   logic pt_on_ff, pt_last_ff;
   logic [mpcpw_pkg::INDEX_W-1:0] pt_row_ff, pt_col_ff;
   logic [mpcpw_pkg::COLOR_W-1:0] pt_red_ff, pt_green_ff, pt_blue_ff;

   // output word register
   logic out_valid_ff, out_valid_in;
   logic [mpcpw_pkg::ADDR_W-1:0] out_addr_ff;
   logic out_on_ff, out_last_ff;
   logic [mpcpw_pkg::COLOR_W-1:0] out_red_ff, out_green_ff, out_blue_ff;

   logic advance;
   logic [mpcpw_pkg::RADIUS_W-1:0] r_sat;
   logic [mpcpw_pkg::STEP_W-1:0] nx, ny;
   logic ny_neg;
   logic signed [mpcpw_pkg::DEC_W-1:0] nd, xe, ye;
   logic gen_final;
   logic [mpcpw_pkg::STEP_W-1:0] off_a, off_b;
   logic signed [PW-1:0] px, py, col_s;
   logic on_pt;
   logic [LW-1:0] lin, addr3;

   // whole pipe moves when the output word is free or being taken
   assign advance = !out_valid_ff || out_ready;

   // next recurrence values
   always_comb begin
      r_sat = (radius > mpcpw_pkg::RADIUS_LIMIT) ? mpcpw_pkg::RADIUS_LIMIT : radius;
      xe    = mpcpw_pkg::DEC_W'(x_ff);
      ye    = mpcpw_pkg::DEC_W'(y_ff);
      nx    = x_ff + 1'b1;
      if (d_ff < 0) begin
         nd     = d_ff + (xe <<< 2) + 8'sd6;
         ny     = y_ff;
         ny_neg = 1'b0;
      end else begin
         nd     = d_ff + ((xe - ye) <<< 2) + 8'sd10;
         ny     = y_ff - 1'b1;
         // radius zero steps y below zero, which ends the circle
         ny_neg = (y_ff == '0);
      end
      gen_final = (oct_ff == mpcpw_pkg::OCT_LAST) && (ny_neg || (nx > ny));
   end

   assign status.advance   = advance;
   assign status.gen_final = gen_final;

   // symmetric point for the current octant
   always_comb begin
      off_a = oct_ff[2] ? y_ff : x_ff;
      off_b = oct_ff[2] ? x_ff : y_ff;
      if (oct_ff[0] ^ oct_ff[1]) begin
         px = PW'(cx_ff) - PW'(off_a);
      end else begin
         px = PW'(cx_ff) + PW'(off_a);
      end
      if (oct_ff[1]) begin
         py = PW'(cy_ff) - PW'(off_b);
      end else begin
         py = PW'(cy_ff) + PW'(off_b);
      end
      on_pt = (px >= 0) && (px < ROWS_S) && (py >= 0) && (py < COLS_S);
      col_s = COLS_S - PW'(1) - py;
   end

   // generator registers
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      d_in   = d_ff;
      oct_in = oct_ff;
      if (cmd.load) begin
         x_in   = '0;
         y_in   = r_sat;
         d_in   = 8'sd3 - (mpcpw_pkg::DEC_W'(r_sat) <<< 1);
         oct_in = '0;
      end else if (cmd.step) begin
         oct_in = oct_ff + 1'b1;
         if (oct_ff == mpcpw_pkg::OCT_LAST) begin
            x_in = nx;
            y_in = ny;
            d_in = nd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         y_ff   <= '0;
         d_ff   <= '0;
         oct_ff <= '0;
      end else begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         d_ff   <= d_in;
         oct_ff <= oct_in;
      end
   end

   // held centre and colour
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff    <= center_x;
         cy_ff    <= center_y;
         red_ff   <= red;
         green_ff <= green;
         blue_ff  <= blue;
      end
   end

   // valid bits of the two stages
   always_comb begin
      pt_valid_in  = pt_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         pt_valid_in  = cmd.step;
         out_valid_in = pt_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pt_valid_ff  <= pt_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // point stage payload
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         pt_on_ff    <= on_pt;
         pt_last_ff  <= gen_final;
         pt_row_ff   <= px[mpcpw_pkg::INDEX_W-1:0];
         pt_col_ff   <= col_s[mpcpw_pkg::INDEX_W-1:0];
         pt_red_ff   <= red_ff;
         pt_green_ff <= green_ff;
         pt_blue_ff  <= blue_ff;
      end
   end

   // byte address: three bytes per pixel, row major over columns
   always_comb begin
      lin   = LW'(pt_row_ff) * COLS_L + LW'(pt_col_ff);
      addr3 = (lin << 1) + lin;
   end

   always_ff @(posedge clock) begin
      if (advance && pt_valid_ff) begin
         out_addr_ff  <= pt_on_ff ? addr3[mpcpw_pkg::ADDR_W-1:0] : '0;
         out_on_ff    <= pt_on_ff;
         out_last_ff  <= pt_last_ff;
         out_red_ff   <= pt_red_ff;
         out_green_ff <= pt_green_ff;
         out_blue_ff  <= pt_blue_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_addr  = out_addr_ff;
   assign out_on    = out_on_ff;
   assign out_last  = out_last_ff;
   assign out_red   = out_red_ff;
   assign out_green = out_green_ff;
   assign out_blue  = out_blue_ff;

endmodule
`default_nettype wire

FILE: dv/midpoint_circle_pixel_writer_unit_test.sv
`default_nettype none
module midpoint_circle_pixel_writer_unit_test;

   localparam int COLUMNS = 240;
   localparam int ROWS    = 400;
   // register map: radius at 4 * index, one unused slot above it
   localparam logic [2:0] RADIUS_ADDR = {mpcpw_pkg::REG_RADIUS, 2'b00};
   localparam logic [2:0] UNUSED_ADDR = 3'd4;
   localparam int IDLE_PERCENT = 16;
   localparam int PRINT_LIMIT  = 40;

   // one expected pixel word
   typedef struct {
      logic [mpcpw_pkg::ADDR_W-1:0]  addr;
      logic                          on_screen;
      logic [mpcpw_pkg::COLOR_W-1:0] red;
      logic [mpcpw_pkg::COLOR_W-1:0] green;
      logic [mpcpw_pkg::COLOR_W-1:0] blue;
      logic                          last;
   } pixel_write_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pixel_write_type                pending_pixels[$];
   logic [mpcpw_pkg::RADIUS_W-1:0] radius_setting;
   int                             mismatch_count;
   logic                           steady_flow;

   midpoint_circle_pixel_writer_unit #(
      .SCREEN_COLUMNS(COLUMNS),
      .SCREEN_ROWS(ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // predicts every pixel write of one circle at the current radius
   function automatic void trace_circle(input logic [mpcpw_pkg::COORD_W-1:0] cx_bits,
                                        input logic [mpcpw_pkg::COORD_W-1:0] cy_bits,
                                        input logic [mpcpw_pkg::COLOR_W-1:0] red,
                                        input logic [mpcpw_pkg::COLOR_W-1:0] green,
                                        input logic [mpcpw_pkg::COLOR_W-1:0] blue);
      int cx, cy, x, y, d, nx, ny, nd, r, k, addr;
      int px [8];
      int py [8];
      logic closing;
      pixel_write_type w;
      r = (radius_setting > mpcpw_pkg::RADIUS_LIMIT) ? int'(mpcpw_pkg::RADIUS_LIMIT)
                                                     : int'(radius_setting);
      cx = $signed(cx_bits);
      cy = $signed(cy_bits);
      x = 0;
      y = r;
      d = 3 - 2 * r;
      while (x <= y) begin
         px[0] = cx + x; py[0] = cy + y;
         px[1] = cx - x; py[1] = cy + y;
         px[2] = cx - x; py[2] = cy - y;
         px[3] = cx + x; py[3] = cy - y;
         px[4] = cx + y; py[4] = cy + x;
         px[5] = cx - y; py[5] = cy + x;
         px[6] = cx - y; py[6] = cy - x;
         px[7] = cx + y; py[7] = cy - x;
         if (d < 0) begin
            nd = d + 4 * x + 6;
            ny = y;
         end else begin
            nd = d + 4 * (x - y) + 10;
            ny = y - 1;
         end
         nx = x + 1;
         closing = nx > ny;
         for (k = 0; k < 8; k++) begin
            w.on_screen = px[k] >= 0 && px[k] < ROWS && py[k] >= 0 && py[k] < COLUMNS;
            addr = w.on_screen ? 3 * (px[k] * COLUMNS + COLUMNS - 1 - py[k]) : 0;
            w.addr = addr[mpcpw_pkg::ADDR_W-1:0];
            w.red = red;
            w.green = green;
            w.blue = blue;
            w.last = closing && k == 7;
            pending_pixels.push_back(w);
         end
         x = nx;
         y = ny;
         d = nd;
      end
   endfunction

   // sends one circle word; enters and leaves at a falling edge, valid left high
   task automatic send_circle(input int cx, input int cy,
                              input logic [mpcpw_pkg::COLOR_W-1:0] red,
                              input logic [mpcpw_pkg::COLOR_W-1:0] green,
                              input logic [mpcpw_pkg::COLOR_W-1:0] blue);
      logic [mpcpw_pkg::COORD_W-1:0] xb, yb;
      int gap;
      xb = 11'(cx);
      yb = 11'(cy);
      gap = 0;
      if (!steady_flow)
         while ($urandom_range(99) < IDLE_PERCENT && gap < 12)
            gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, blue, green, red, yb, xb};
      do
         @(posedge clock);
      while (!req_tready);
      trace_circle(xb, yb, red, green, blue);
      @(negedge clock);
   endtask

   // holds the sender until every expected pixel word has come out
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(negedge clock);
   endtask

   // register write, setup then access; only called with the block drained
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == RADIUS_ADDR)
         radius_setting = value[mpcpw_pkg::RADIUS_W-1:0];
   endtask

   task automatic set_radius(input logic [31:0] value);
      drain_pixels();
      write_register(RADIUS_ADDR, value);
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= steady_flow || $urandom_range(99) >= IDLE_PERCENT;
   end

   // compare each pixel word with the oldest expectation
   always @(posedge clock) begin
      pixel_write_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel word %h", rsp_tdata));
         end else begin
            w = pending_pixels.pop_front();
            if (rsp_tdata[18:0] !== w.addr)
               report_mismatch($sformatf("byte_address %0d, want %0d", rsp_tdata[18:0], w.addr));
            if (rsp_tuser[0] !== w.on_screen)
               report_mismatch($sformatf("on_screen %b, want %b", rsp_tuser[0], w.on_screen));
            if (rsp_tdata[26:19] !== w.red)
               report_mismatch($sformatf("pixel_red %h, want %h", rsp_tdata[26:19], w.red));
            if (rsp_tdata[34:27] !== w.green)
               report_mismatch($sformatf("pixel_green %h, want %h", rsp_tdata[34:27], w.green));
            if (rsp_tdata[42:35] !== w.blue)
               report_mismatch($sformatf("pixel_blue %h, want %h", rsp_tdata[42:35], w.blue));
            if (rsp_tlast !== w.last)
               report_mismatch($sformatf("last %b, want %b", rsp_tlast, w.last));
         end
      end
   end

   // circles at the reset radius, colour extremes
   task automatic test_reset_radius();
      send_circle(200, 120, 8'h00, 8'h00, 8'h00);
      send_circle(0, 0, 8'hFF, 8'hFF, 8'hFF);
      send_circle(399, 239, 8'hA5, 8'h5A, 8'h0F);
   endtask

   // radius zero gives the centre eight times, radius one a tiny ring
   task automatic test_small_radii();
      set_radius(0);
      send_circle(0, 0, 8'h01, 8'h02, 8'h03);
      send_circle(399, 239, 8'h80, 8'h40, 8'h20);
      send_circle(400, 239, 8'h7F, 8'hFE, 8'hFD);
      set_radius(1);
      send_circle(0, 239, 8'h11, 8'h22, 8'h33);
      send_circle(399, 0, 8'hC3, 8'h3C, 8'h99);
   endtask

   // radius above the limit is clipped; the unused register slot is ignored
   task automatic test_radius_saturation();
      set_radius(11);
      send_circle(100, 100, 8'hF0, 8'h0F, 8'hAA);
      set_radius(15);
      send_circle(-5, 244, 8'h55, 8'hAA, 8'hFF);
      drain_pixels();
      write_register(UNUSED_ADDR, 32'hFFFF_FFF0);
      send_circle(300, 50, 8'h12, 8'h34, 8'h56);
   endtask

   // centres at the coordinate extremes and just past the screen edges
   task automatic test_screen_edges();
      set_radius(3);
      send_circle(-1024, -1024, 8'hFF, 8'h00, 8'hFF);
      send_circle(1023, 1023, 8'h00, 8'hFF, 8'h00);
      send_circle(-1024, 1023, 8'h81, 8'h18, 8'h42);
      send_circle(1023, -1024, 8'h24, 8'h81, 8'h7E);
      send_circle(-1, 120, 8'h01, 8'h80, 8'h10);
      send_circle(400, 120, 8'h08, 8'h04, 8'h02);
      send_circle(200, -1, 8'hE7, 8'h7E, 8'hDB);
      send_circle(200, 240, 8'h3F, 8'hC0, 8'h0C);
   endtask

   // random circles in phases of fixed or random radius, mostly around the screen
   task automatic test_random_circles();
      int phase, n, cx, cy;
      logic [31:0] r;
      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            0: r = 10;
            1: r = 0;
            2: r = 15;
            3: r = 11;
            default: r = $urandom_range(15);
         endcase
         set_radius(r);
         steady_flow = (phase == 0);
         for (n = 0; n < 40; n++) begin
            if ($urandom_range(4) == 0) begin
               cx = int'($urandom_range(2047)) - 1024;
               cy = int'($urandom_range(2047)) - 1024;
            end else begin
               cx = int'($urandom_range(ROWS + 23)) - 12;
               cy = int'($urandom_range(COLUMNS + 23)) - 12;
            end
            if ((phase == 5 && n == 20) || $urandom_range(39) == 0)
               drain_pixels();
            send_circle(cx, cy, 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      radius_setting = mpcpw_pkg::RADIUS_RESET;
      mismatch_count = 0;
      steady_flow = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_reset_radius();
      test_small_radii();
      test_radius_saturation();
      test_screen_edges();
      test_random_circles();

      // let the pipe drain and watch for stray words
      drain_pixels();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
